### hdl/lqlf_pkg.sv
// Package for the lock qualifier: mode and event codes, register map,
// beat and configuration structures. No dependencies.

package lqlf_pkg;

	localparam int unsigned NowW   = 32;
	localparam int unsigned HoldW  = 20;
	localparam int unsigned LimitW = 8;
	localparam int unsigned AddrW  = 4;
	localparam int unsigned DataW  = 32;
	localparam int unsigned InTdataW  = 40;
	localparam int unsigned OutTdataW = 8;

	localparam logic [LimitW-1:0] LimitReset  = 8'd3;
	localparam logic [HoldW-1:0]  StableReset = 20'd5000;
	localparam logic [HoldW-1:0]  MinReset    = 20'd0;
	localparam logic [LimitW-1:0] CountMax    = 8'hFF;

	typedef enum logic [1:0] {
		REG_LIMIT  = 2'd0,
		REG_STABLE = 2'd1,
		REG_MIN    = 2'd2,
		REG_NONE   = 2'd3
	} reg_idx_t;

	typedef enum logic [1:0] {
		MODE_QUAL   = 2'd0,
		MODE_STABLE = 2'd1,
		MODE_LOST   = 2'd2
	} mode_t;

	typedef enum logic [2:0] {
		EV_NONE           = 3'd0,
		EV_STABLE_RESET   = 3'd1,
		EV_LOCK_LOST      = 3'd2,
		EV_STABLE_START   = 3'd3,
		EV_STABLE_REACHED = 3'd4
	} event_t;

	localparam logic FUNC_UPDATE  = 1'b0;
	localparam logic FUNC_RESTART = 1'b1;

	typedef struct packed {
		logic [LimitW-1:0] bad_windows_limit;
		logic [HoldW-1:0]  stable_hold_ms;
		logic [HoldW-1:0]  min_lock_hold_ms;
	} cfg_t;

	typedef struct packed {
		logic            func;
		logic            win_good;
		logic [NowW-1:0] now_ms;
	} item_t;

	typedef struct packed {
		mode_t  lock_mode;
		event_t event_code;
		logic   is_lost;
		logic   became_stable;
	} result_t;

endpackage

### hdl/lqlf_regs.sv
// APB configuration registers of the lock qualifier.
// Depends on lqlf_pkg.

module lqlf_regs import lqlf_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             psel,
	input  logic             penable,
	input  logic             pwrite,
	input  logic [AddrW-1:0] paddr,
	input  logic [DataW-1:0] pwdata,
	output logic [DataW-1:0] prdata,
	output cfg_t             cfg
);

	cfg_t     cfg_q;
	reg_idx_t idx;
	logic     wr_en;

	assign idx   = reg_idx_t'(paddr[3:2]);
	assign wr_en = psel & penable & pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.bad_windows_limit <= LimitReset;
			cfg_q.stable_hold_ms    <= StableReset;
			cfg_q.min_lock_hold_ms  <= MinReset;
		end else if (wr_en) begin
			case (idx)
				REG_LIMIT:  cfg_q.bad_windows_limit <= pwdata[LimitW-1:0];
				REG_STABLE: cfg_q.stable_hold_ms    <= pwdata[HoldW-1:0];
				REG_MIN:    cfg_q.min_lock_hold_ms  <= pwdata[HoldW-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			REG_LIMIT:  prdata = {{(DataW-LimitW){1'b0}}, cfg_q.bad_windows_limit};
			REG_STABLE: prdata = {{(DataW-HoldW){1'b0}}, cfg_q.stable_hold_ms};
			REG_MIN:    prdata = {{(DataW-HoldW){1'b0}}, cfg_q.min_lock_hold_ms};
			default:    prdata = '0;
		endcase
	end

	assign cfg = cfg_q;

endmodule

### hdl/lqlf_core.sv
// Lock tracking state machine: mode, good run, lock start and bad count,
// with the combinational next-state and result logic. Depends on lqlf_pkg.

module lqlf_core import lqlf_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    advance,
	input  item_t   item,
	input  cfg_t    cfg,
	output result_t result
);

	mode_t             mode_q, mode_d;
	logic              good_valid_q, good_valid_d;
	logic [NowW-1:0]   good_start_q, good_start_d;
	logic [NowW-1:0]   lock_start_q, lock_start_d;
	logic [LimitW-1:0] bad_cnt_q, bad_cnt_d;

	logic [LimitW-1:0] limit;
	logic [LimitW-1:0] cnt_inc;
	logic [NowW-1:0]   since_lock;
	logic [NowW-1:0]   run_start;
	logic [NowW-1:0]   run_len;
	event_t            ev;
	logic              reached;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q       <= MODE_QUAL;
			good_valid_q <= 1'b0;
			good_start_q <= '0;
			lock_start_q <= '0;
			bad_cnt_q    <= '0;
		end else if (advance) begin
			mode_q       <= mode_d;
			good_valid_q <= good_valid_d;
			good_start_q <= good_start_d;
			lock_start_q <= lock_start_d;
			bad_cnt_q    <= bad_cnt_d;
		end
	end

	assign limit      = (cfg.bad_windows_limit == '0) ? LimitW'(1) : cfg.bad_windows_limit;
	assign cnt_inc    = (bad_cnt_q == CountMax) ? bad_cnt_q : bad_cnt_q + LimitW'(1);
	assign since_lock = item.now_ms - lock_start_q;
	assign run_start  = good_valid_q ? good_start_q : item.now_ms;
	assign run_len    = item.now_ms - run_start;

	always_comb begin
		mode_d       = mode_q;
		good_valid_d = good_valid_q;
		good_start_d = good_start_q;
		lock_start_d = lock_start_q;
		bad_cnt_d    = bad_cnt_q;
		ev           = EV_NONE;
		reached      = 1'b0;
		if (item.func == FUNC_RESTART) begin
			mode_d       = MODE_QUAL;
			good_valid_d = 1'b0;
			lock_start_d = item.now_ms;
			bad_cnt_d    = '0;
		end else if (mode_q == MODE_LOST) begin
			mode_d = MODE_LOST;
		end else if (!item.win_good) begin
			good_valid_d = 1'b0;
			if (mode_q == MODE_STABLE) begin
				mode_d = MODE_QUAL;
				ev     = EV_STABLE_RESET;
			end
			if (since_lock < {{(NowW-HoldW){1'b0}}, cfg.min_lock_hold_ms}) begin
				bad_cnt_d = '0;
			end else begin
				bad_cnt_d = cnt_inc;
				if (cnt_inc >= limit) begin
					mode_d = MODE_LOST;
					ev     = EV_LOCK_LOST;
				end
			end
		end else begin
			bad_cnt_d = '0;
			if (!good_valid_q) begin
				good_valid_d = 1'b1;
				good_start_d = item.now_ms;
				ev           = EV_STABLE_START;
			end
			if (mode_q == MODE_QUAL &&
			    run_len >= {{(NowW-HoldW){1'b0}}, cfg.stable_hold_ms}) begin
				mode_d  = MODE_STABLE;
				ev      = EV_STABLE_REACHED;
				reached = 1'b1;
			end
		end
		result.lock_mode     = mode_d;
		result.event_code    = ev;
		result.is_lost       = (mode_d == MODE_LOST);
		result.became_stable = reached;
	end

endmodule

### hdl/lock_qualify_lose_fsm.sv
// Top level of the lock qualifier: input register, tracking core, result
// register and APB configuration. Depends on lqlf_pkg, lqlf_regs, lqlf_core.
//
// Input beats arrive on the s_ group: tuser carries func (1 = restart,
// 0 = window verdict), tdata carries win_good and now_ms. Each beat gives
// exactly one result beat on the m_ group with the state after the beat,
// its event code, the lost flag and the stable-reached flag.
// An accepted beat is held in the input register and is evaluated against
// the tracking state by the core; when the core advances, its result is
// loaded into the result register and offered. One beat per cycle is
// sustained while the receiver does not stall; the loop through the
// tracking state closes through the combinational core logic.
// When the receiver stalls, the result register holds and the input register
// fills; s_tready falls only when both are full, and no state changes until
// the held beat can move on.
// Reset clears the state to qualifying with no good run, a zero lock start
// and a zero bad count, and loads the register reset values. The user must write
// registers over APB only while no beat is in flight; the block does not enforce it.

module lock_qualify_lose_fsm import lqlf_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [InTdataW-1:0]  s_tdata,  // [0] win_good, [32:1] now_ms, rest zero
	input  logic                 s_tuser,  // [0] func
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [OutTdataW-1:0] m_tdata,  // [1:0] lock_mode, [4:2] event_code,
	                                       // [5] is_lost, [6] became_stable, [7] zero
	input  logic                 psel,
	input  logic                 penable,
	input  logic                 pwrite,
	input  logic [AddrW-1:0]     paddr,
	input  logic [DataW-1:0]     pwdata,
	output logic [DataW-1:0]     prdata,
	output logic                 pready
);

	cfg_t    cfg;
	item_t   item_s1;
	logic    valid_s1;
	result_t res_d;
	result_t res_s2;
	logic    valid_s2;
	logic    advance;

	assign pready = 1'b1;

	lqlf_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.cfg     (cfg)
	);

	assign advance  = valid_s1 & (~valid_s2 | m_tready);
	assign s_tready = ~valid_s1 | advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (s_tready) begin
				valid_s1 <= s_tvalid;
			end
			if (advance) begin
				valid_s2 <= 1'b1;
			end else if (m_tready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			item_s1.func     <= s_tuser;
			item_s1.win_good <= s_tdata[0];
			item_s1.now_ms   <= s_tdata[NowW:1];
		end
		if (advance) begin
			res_s2 <= res_d;
		end
	end

	lqlf_core u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.advance (advance),
		.item    (item_s1),
		.cfg     (cfg),
		.result  (res_d)
	);

	assign m_tvalid = valid_s2;
	assign m_tdata  = {1'b0, res_s2.became_stable, res_s2.is_lost,
	                   res_s2.event_code, res_s2.lock_mode};

	a_lost_flag: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[5] == (m_tdata[1:0] == MODE_LOST)))
		else $error("is_lost disagrees with lock_mode");

	a_reached: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tdata[6]) |->
		(m_tdata[4:2] == EV_STABLE_REACHED && m_tdata[1:0] == MODE_STABLE))
		else $error("became_stable without stable reached event");

	a_restart: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && item_s1.func == FUNC_RESTART) |=>
		(m_tvalid && m_tdata[1:0] == MODE_QUAL && m_tdata[4:2] == EV_NONE))
		else $error("restart beat did not give a clean qualifying result");

endmodule

### verif/tb_lock_qualify_lose_fsm.sv
`timescale 1ns / 100ps
// Self-checking testbench for lock_qualify_lose_fsm: drives window and restart
// beats with random gaps and back-pressure, predicts every result beat and
// checks it field by field. Depends on lqlf_pkg and the block's RTL.

module tb_lock_qualify_lose_fsm;
	import lqlf_pkg::*;

	localparam int unsigned CycleLimit = 200000;

	logic                 clk;
	logic                 arst_n;
	logic                 s_tvalid;
	logic                 s_tready;
	logic [InTdataW-1:0]  s_tdata;  // [0] win_good, [32:1] now_ms, rest zero
	logic                 s_tuser;  // [0] func
	logic                 m_tvalid;
	logic                 m_tready;
	logic [OutTdataW-1:0] m_tdata;  // [1:0] lock_mode, [4:2] event_code,
	                                // [5] is_lost, [6] became_stable, [7] zero
	logic                 psel;
	logic                 penable;
	logic                 pwrite;
	logic [AddrW-1:0]     paddr;
	logic [DataW-1:0]     pwdata;
	logic [DataW-1:0]     prdata;
	logic                 pready;

	lock_qualify_lose_fsm dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	mode_t             tk_mode;
	logic              tk_run_valid;
	logic [NowW-1:0]   tk_run_start;
	logic [NowW-1:0]   tk_lock_start;
	logic [LimitW-1:0] tk_bad_count;
	cfg_t              tk_cfg;

	result_t           pending_results[$];
	int unsigned       errors;
	int unsigned       cycles;
	int unsigned       send_idle_pct;
	int unsigned       recv_idle_pct;
	int unsigned       hold_left;
	logic [NowW-1:0]   now_cursor;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic result_t lock_track(input logic func, input logic good,
		input logic [NowW-1:0] now);
		result_t           r;
		event_t            ev;
		logic              reached;
		logic [LimitW-1:0] lim;
		logic [NowW-1:0]   since_lock;
		logic [NowW-1:0]   since_run;
		ev = EV_NONE;
		reached = 1'b0;
		lim = (tk_cfg.bad_windows_limit == '0) ? LimitW'(1) : tk_cfg.bad_windows_limit;
		since_lock = now - tk_lock_start;
		if (func == FUNC_RESTART) begin
			tk_mode = MODE_QUAL;
			tk_run_valid = 1'b0;
			tk_lock_start = now;
			tk_bad_count = '0;
		end else if (tk_mode == MODE_LOST) begin
			// A lost lock holds until the next restart.
		end else if (!good) begin
			tk_run_valid = 1'b0;
			if (tk_mode == MODE_STABLE) begin
				tk_mode = MODE_QUAL;
				ev = EV_STABLE_RESET;
			end
			if (since_lock < NowW'(tk_cfg.min_lock_hold_ms)) begin
				tk_bad_count = '0;
			end else begin
				if (tk_bad_count != CountMax)
					tk_bad_count = tk_bad_count + 1'b1;
				if (tk_bad_count >= lim) begin
					tk_mode = MODE_LOST;
					ev = EV_LOCK_LOST;
				end
			end
		end else begin
			tk_bad_count = '0;
			if (!tk_run_valid) begin
				tk_run_valid = 1'b1;
				tk_run_start = now;
				ev = EV_STABLE_START;
			end
			since_run = now - tk_run_start;
			if (tk_mode == MODE_QUAL && since_run >= NowW'(tk_cfg.stable_hold_ms)) begin
				tk_mode = MODE_STABLE;
				ev = EV_STABLE_REACHED;
				reached = 1'b1;
			end
		end
		r.lock_mode = tk_mode;
		r.event_code = ev;
		r.is_lost = (tk_mode == MODE_LOST);
		r.became_stable = reached;
		return r;
	endfunction

	task automatic report_mismatch(input string what, input logic [DataW-1:0] want,
		input logic [DataW-1:0] got);
		errors++;
		$display("%0t: %s mismatch, expected %0d actual %0d", $time, what, want, got);
	endtask

	task automatic send_window(input logic func, input logic good, input logic [NowW-1:0] now);
		while ($urandom_range(99) < send_idle_pct) begin
			@(negedge clk);
			s_tvalid <= 1'b0;
		end
		@(negedge clk);
		s_tvalid <= 1'b1;
		s_tuser <= func;
		s_tdata <= {{(InTdataW - NowW - 1){1'b0}}, now, good};
		do @(posedge clk); while (!s_tready);
		pending_results.push_back(lock_track(func, good, now));
	endtask

	task automatic finish_phase();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic apb_access(input logic write, input reg_idx_t idx,
		input logic [DataW-1:0] wdata, output logic [DataW-1:0] rdata);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= write;
		paddr <= AddrW'({idx, 2'b00});
		pwdata <= wdata;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		rdata = prdata;
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic set_register(input reg_idx_t idx, input logic [DataW-1:0] value);
		logic [DataW-1:0] readback;
		logic [DataW-1:0] stored;
		case (idx)
			REG_LIMIT: begin
				tk_cfg.bad_windows_limit = value[LimitW-1:0];
				stored = DataW'(value[LimitW-1:0]);
			end
			REG_STABLE: begin
				tk_cfg.stable_hold_ms = value[HoldW-1:0];
				stored = DataW'(value[HoldW-1:0]);
			end
			default: begin
				tk_cfg.min_lock_hold_ms = value[HoldW-1:0];
				stored = DataW'(value[HoldW-1:0]);
			end
		endcase
		apb_access(1'b1, idx, value, readback);
		apb_access(1'b0, idx, '0, readback);
		if (readback !== stored)
			report_mismatch("register readback", stored, readback);
	endtask

	task automatic config_all(input int unsigned limit, input int unsigned hold,
		input int unsigned min_hold);
		set_register(REG_LIMIT, limit);
		set_register(REG_STABLE, hold);
		set_register(REG_MIN, min_hold);
	endtask

	// Mostly restart-led runs of windows with drifting time, some noise beats.
	task automatic run_lock_sequences(input int unsigned count);
		int unsigned sent;
		int unsigned windows;
		int unsigned good_pct;
		int unsigned span;
		sent = 0;
		span = tk_cfg.stable_hold_ms / 3 + tk_cfg.min_lock_hold_ms / 3 + 4;
		while (sent < count) begin
			if ($urandom_range(99) < 10) begin
				send_window(1'($urandom_range(1)), 1'($urandom_range(1)), $urandom);
				sent++;
			end else begin
				if ($urandom_range(99) < 20)
					now_cursor = $urandom;
				send_window(FUNC_RESTART, 1'($urandom_range(1)), now_cursor);
				good_pct = $urandom_range(50, 97);
				windows = $urandom_range(3, 20);
				sent += windows + 1;
				repeat (windows) begin
					if ($urandom_range(99) < 4)
						now_cursor -= $urandom_range(1, span);
					else
						now_cursor += $urandom_range(0, span);
					send_window(FUNC_UPDATE, $urandom_range(99) < good_pct, now_cursor);
				end
			end
		end
	endtask

	task automatic test_after_reset();
		send_window(FUNC_UPDATE, 1'b1, 32'd0);
		send_window(FUNC_UPDATE, 1'b1, 32'd4999);
		send_window(FUNC_UPDATE, 1'b1, 32'd5000);
		send_window(FUNC_UPDATE, 1'b1, 32'd9000);
		send_window(FUNC_UPDATE, 1'b0, 32'd9001);
		send_window(FUNC_UPDATE, 1'b0, 32'd9002);
		send_window(FUNC_UPDATE, 1'b0, 32'd9003);
		send_window(FUNC_UPDATE, 1'b1, 32'd9004);
		send_window(FUNC_UPDATE, 1'b0, 32'd9005);
		send_window(FUNC_RESTART, 1'b1, 32'hFFFF_FFF0);
		send_window(FUNC_UPDATE, 1'b1, 32'hFFFF_FFFF);
		send_window(FUNC_UPDATE, 1'b1, 32'h0000_1387);
		send_window(FUNC_UPDATE, 1'b0, 32'h0000_0000);
	endtask

	task automatic test_special_cases();
		finish_phase();
		config_all(0, 0, 100);
		send_window(FUNC_RESTART, 1'b0, 32'd1000);
		send_window(FUNC_UPDATE, 1'b1, 32'd1000);
		send_window(FUNC_UPDATE, 1'b0, 32'd1050);
		send_window(FUNC_UPDATE, 1'b0, 32'd1100);
		send_window(FUNC_RESTART, 1'b1, 32'd2000);
		send_window(FUNC_UPDATE, 1'b1, 32'd2200);
		send_window(FUNC_UPDATE, 1'b0, 32'd2300);
		send_window(FUNC_RESTART, 1'b0, 32'd5000);
		send_window(FUNC_UPDATE, 1'b0, 32'd4000);
		send_window(FUNC_RESTART, 1'b0, 32'd6000);
		send_window(FUNC_UPDATE, 1'b1, 32'd6000);
		send_window(FUNC_UPDATE, 1'b1, 32'd6001);
	endtask

	task automatic test_count_limit();
		int unsigned i;
		finish_phase();
		config_all(255, 5000, 0);
		send_window(FUNC_RESTART, 1'b0, 32'd0);
		for (i = 1; i <= 258; i++)
			send_window(FUNC_UPDATE, 1'b0, i);
	endtask

	task automatic test_backpressure();
		finish_phase();
		config_all(2, 40, 10);
		send_idle_pct = 0;
		hold_left = 300;
		run_lock_sequences(60);
	endtask

	task automatic test_random();
		int unsigned send_pcts[3] = '{23, 45, 0};
		int unsigned recv_pcts[3] = '{45, 23, 0};
		int unsigned limits[6] = '{3, 1, 255, 0, 4, 2};
		int unsigned holds[6] = '{5000, 0, 1048575, 20, 300, 1048575};
		int unsigned mins[6] = '{0, 0, 1048575, 10, 100, 0};
		int unsigned p;
		int unsigned c;
		for (p = 0; p < 3; p++) begin
			for (c = 0; c < 6; c++) begin
				finish_phase();
				send_idle_pct = send_pcts[p];
				recv_idle_pct = recv_pcts[p];
				config_all(limits[c], holds[c], mins[c]);
				run_lock_sequences(50);
			end
		end
	endtask

	initial begin
		forever begin
			@(negedge clk);
			if (hold_left != 0) begin
				m_tready <= 1'b0;
				hold_left = hold_left - 1;
			end else begin
				m_tready <= ($urandom_range(99) >= recv_idle_pct);
			end
		end
	end

	always @(posedge clk) begin : check_result
		result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_results.size() == 0) begin
				errors++;
				$display("%0t: result beat with none expected, actual %0h", $time, m_tdata);
			end else begin
				want = pending_results.pop_front();
				if (m_tdata[1:0] !== want.lock_mode)
					report_mismatch("lock_mode", want.lock_mode, m_tdata[1:0]);
				if (m_tdata[4:2] !== want.event_code)
					report_mismatch("event_code", want.event_code, m_tdata[4:2]);
				if (m_tdata[5] !== want.is_lost)
					report_mismatch("is_lost", want.is_lost, m_tdata[5]);
				if (m_tdata[6] !== want.became_stable)
					report_mismatch("became_stable", want.became_stable, m_tdata[6]);
			end
		end
	end

	initial begin
		cycles = 0;
		while (cycles < CycleLimit) begin
			@(posedge clk);
			cycles++;
		end
		$display("tb_lock_qualify_lose_fsm: FAIL");
		$finish;
	end

	initial begin
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = 1'b0;
		m_tready = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		errors = 0;
		hold_left = 0;
		now_cursor = '0;
		send_idle_pct = 23;
		recv_idle_pct = 45;
		tk_mode = MODE_QUAL;
		tk_run_valid = 1'b0;
		tk_run_start = '0;
		tk_lock_start = '0;
		tk_bad_count = '0;
		tk_cfg.bad_windows_limit = LimitReset;
		tk_cfg.stable_hold_ms = StableReset;
		tk_cfg.min_lock_hold_ms = MinReset;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_after_reset();
		test_special_cases();
		test_count_limit();
		test_backpressure();
		test_random();
		finish_phase();
		repeat (10) @(posedge clk);

		if (errors == 0)
			$display("tb_lock_qualify_lose_fsm: PASS");
		else
			$display("tb_lock_qualify_lose_fsm: FAIL");
		$finish;
	end

endmodule
